FILE: rtl/pcbl_pkg.sv
// Shared types, codes and reset values for the pulse-count backlight controller.
`default_nettype none

package pcbl_pkg;

    typedef enum logic [1:0] {
        CMD_SET_LEVEL = 2'd0,
        CMD_SUSPEND   = 2'd1,
        CMD_RESUME    = 2'd2,
        CMD_TICK      = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HOLD = 2'd1,
        PH_KEEP = 2'd2,
        PH_LOW  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        CFG_HOLD_TICKS  = 2'd0,
        CFG_PULSE_TICKS = 2'd1,
        CFG_STEP_COUNT  = 2'd2
    } cfg_idx_t;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned OUT_DATA_W = 8;

    localparam logic [15:0] HOLD_TICKS_RST  = 16'd3000;
    localparam logic [7:0]  PULSE_TICKS_RST = 8'd1;
    localparam logic [4:0]  STEP_COUNT_RST  = 5'd17;
    localparam logic [7:0]  SAVED_LEVEL_RST = 8'd1;
    localparam logic [3:0]  LEVEL_MAX       = 4'd15;

    typedef struct packed {
        logic [15:0] hold_ticks;
        logic [7:0]  pulse_ticks;
        logic [4:0]  step_count;
    } cfg_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [7:0]  level;
    } item_t;

    typedef struct packed {
        logic rejected;
        logic busy_res;
        logic line;
    } result_t;

    // Pulse count for a raw signed level: step_count minus level clamped to 0..15.
    function automatic logic [4:0] pulses_for(input logic [7:0] raw, input logic [4:0] step);
        logic [4:0] lv;
        begin
            if (raw[7])
                lv = 5'd0;
            else if (raw[6:0] > {3'd0, LEVEL_MAX})
                lv = {1'b0, LEVEL_MAX};
            else
                lv = {1'b0, raw[3:0]};
            pulses_for = (step > lv) ? (step - lv) : 5'd0;
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/pcbl_cfg_regs.sv
// Configuration register file: hold time, half-pulse time and step count.
`default_nettype none

module pcbl_cfg_regs
    import pcbl_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg        = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_HOLD_TICKS:  cfg_next.hold_ticks  = cfg_data;
                CFG_PULSE_TICKS: cfg_next.pulse_ticks = cfg_data[7:0];
                CFG_STEP_COUNT:  cfg_next.step_count  = cfg_data[4:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_ticks  <= HOLD_TICKS_RST;
            cfg_reg.pulse_ticks <= PULSE_TICKS_RST;
            cfg_reg.step_count  <= STEP_COUNT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pcbl_in_stage.sv
// Input register: capture one command word and hold it until the core takes it.
`default_nettype none

module pcbl_in_stage
    import pcbl_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [1:0] s_tuser,
    input  wire logic [7:0] s_tdata,
    input  wire logic       take,
    output logic            item_valid,
    output item_t           item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  s_accept;

    assign s_tready   = !valid_reg || take;
    assign s_accept   = s_tvalid && s_tready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_accept)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            item_reg.cmd   <= cmd_t'(s_tuser);
            item_reg.level <= s_tdata;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pcbl_core.sv
// Sequencer core: line state, hold/pulse phase counters and command decode.
`default_nettype none

module pcbl_core
    import pcbl_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  fire,
    input  wire item_t item,
    output result_t    result
);

    logic        line_reg,      line_next;
    logic        suspended_reg, suspended_next;
    logic [7:0]  saved_reg,     saved_next;
    phase_t      phase_reg,     phase_next;
    logic [15:0] tick_reg,      tick_next;
    logic [4:0]  pulses_reg,    pulses_next;
    logic        rejected;

    logic [15:0] hold_dur;
    logic [15:0] pulse_dur;
    logic [4:0]  start_pulses;

    assign hold_dur  = (cfg.hold_ticks == 16'd0) ? 16'd1 : cfg.hold_ticks;
    assign pulse_dur = (cfg.pulse_ticks == 8'd0) ? 16'd1 : {8'd0, cfg.pulse_ticks};

    // Resume replays the stored level, set level uses the fresh one.
    assign start_pulses = pulses_for((item.cmd == CMD_RESUME) ? saved_reg : item.level,
                                     cfg.step_count);

    always_comb
    begin
        line_next      = line_reg;
        suspended_next = suspended_reg;
        saved_next     = saved_reg;
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        pulses_next    = pulses_reg;
        rejected       = 1'b0;

        if (item.cmd == CMD_TICK)
        begin
            if (phase_reg != PH_IDLE)
            begin
                if (tick_reg > 16'd1)
                begin
                    tick_next = tick_reg - 16'd1;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_HOLD:
                        begin
                            if (pulses_reg != 5'd0)
                            begin
                                phase_next = PH_KEEP;
                                tick_next  = pulse_dur;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                                tick_next  = 16'd0;
                            end
                        end
                        PH_KEEP:
                        begin
                            line_next  = 1'b0;
                            phase_next = PH_LOW;
                            tick_next  = pulse_dur;
                        end
                        PH_LOW:
                        begin
                            line_next   = 1'b1;
                            pulses_next = pulses_reg - 5'd1;
                            if (pulses_reg != 5'd1)
                            begin
                                phase_next = PH_KEEP;
                                tick_next  = pulse_dur;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                                tick_next  = 16'd0;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            rejected = 1'b1;
        end
        else
        begin
            // Commands that reach here start a hold, except a nonzero level while suspended.
            if (item.cmd == CMD_SET_LEVEL && item.level != 8'd0 && suspended_reg)
            begin
                saved_next = item.level;
            end
            else
            begin
                line_next  = 1'b0;
                phase_next = PH_HOLD;
                tick_next  = hold_dur;
                if (item.cmd == CMD_SUSPEND || item.level == 8'd0 && item.cmd == CMD_SET_LEVEL)
                    pulses_next = 5'd0;
                else
                    pulses_next = start_pulses;
                if (item.cmd == CMD_SUSPEND)
                    suspended_next = 1'b1;
                else if (item.cmd == CMD_RESUME)
                    suspended_next = 1'b0;
            end
        end
    end

    assign result.line     = line_next;
    assign result.busy_res = (phase_next != PH_IDLE);
    assign result.rejected = rejected;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg      <= 1'b0;
            suspended_reg <= 1'b0;
            saved_reg     <= SAVED_LEVEL_RST;
            phase_reg     <= PH_IDLE;
            tick_reg      <= 16'd0;
            pulses_reg    <= 5'd0;
        end
        else if (fire)
        begin
            line_reg      <= line_next;
            suspended_reg <= suspended_next;
            saved_reg     <= saved_next;
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            pulses_reg    <= pulses_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pcbl_out_stage.sv
// Result register: hold one result word until the sink takes it.
`default_nettype none

module pcbl_out_stage
    import pcbl_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load,
    input  wire result_t               result,
    output logic                       can_load,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign can_load = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - 3){1'b0}}, result_reg};

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result;
    end

endmodule

`default_nettype wire

FILE: rtl/pulse_count_backlight_controller.sv
// Top level of the single-wire pulse-count backlight controller.
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  -------------------------------------
//  s_       in         s_tvalid / s_tready       s_tuser[1:0] cmd, s_tdata[7:0] level
//  m_       out        m_tvalid / m_tready       m_tdata[0] line, [1] busy_res,
//                                                [2] rejected, [7:3] zero
//  cfg_     in         cfg_valid / cfg_ready     cfg_index[1:0], cfg_data[15:0]
//
// One command word is taken per cycle while the sink keeps up. Each result word is
// written into the result register when the core takes its command from the input
// register, which waits while the result register is full and not being drained.
// The core's state update is one compare/decrement of the 16-bit tick counter.
// Reset clears the line low, drops the suspend mark, restores the stored level to 1,
// idles the sequencer and loads the hold, half-pulse and step registers with 3000, 1, 17.
// While m_tready is low the result word holds, the input register takes one more word,
// and then s_tready drops until the sink drains. cfg_ready is always high.
`default_nettype none

module pulse_count_backlight_controller
    import pcbl_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [1:0]            s_tuser,   // [1:0] cmd
    input  wire logic [7:0]            s_tdata,   // [7:0] level (signed)
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // [0] line, [1] busy_res, [2] rejected
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    item_t   item;
    logic    item_valid;
    logic    out_can_load;
    logic    fire;
    result_t result;

    // Advance the core only when a command is waiting and the result register has room.
    assign fire = item_valid && out_can_load;

    pcbl_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pcbl_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    pcbl_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .fire   (fire),
        .item   (item),
        .result (result)
    );

    pcbl_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire),
        .result   (result),
        .can_load (out_can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

FILE: rtl/pcbl_checker.sv
// Port-level checker for the backlight controller, bound to the top level.
`default_nettype none

module pcbl_checker
    import pcbl_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata,
    input wire logic                  cfg_valid,
    input wire logic                  cfg_ready
);

    // A stalled result word must hold.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result word changed while stalled");

    // A rejected command only happens while a sequence is running, which keeps running.
    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[2]) |-> m_tdata[1])
        else $error("rejected result without busy");

    // Padding bits of the result word stay zero.
    a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_DATA_W-1:3] == '0))
        else $error("result padding not zero");

    // Register writes are never back-pressured.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind pulse_count_backlight_controller pcbl_checker u_pcbl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

`default_nettype wire

FILE: tb/tb_pulse_count_backlight_controller.sv
// Self-checking testbench for the pulse-count backlight controller: directed table, then random commands.
`timescale 1ns / 100ps

module tb_pulse_count_backlight_controller;
    import pcbl_pkg::*;

    // Cycles with no handshake on any channel before the run is declared hung.
    localparam int STALL_LIMIT = 2000;
    // Rows of the directed table that run with the reset register values.
    localparam int RESET_ROWS  = 1;
    localparam int PLAN_LEN    = 23;
    localparam int NUM_PHASES  = 6;
    // Upper bound on ticks spent finishing one running sequence.
    localparam int SETTLE_CAP  = 20000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser   = CMD_TICK;   // [1:0] cmd
    logic [7:0]  s_tdata   = 8'h00;      // [7:0] level (signed)
    logic        m_tvalid;
    logic        m_tready  = 1'b1;
    logic [OUT_DATA_W-1:0] m_tdata;      // [0] line, [1] busy_res, [2] rejected
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_HOLD_TICKS;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    pulse_count_backlight_controller DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Line predictor: register copies and sequencer state
    // ------------------------------------------------------------------
    logic [15:0] cfg_hold  = HOLD_TICKS_RST;
    logic [7:0]  cfg_pulse = PULSE_TICKS_RST;
    logic [4:0]  cfg_step  = STEP_COUNT_RST;

    logic        pr_line      = 1'b0;
    logic        pr_suspended = 1'b0;
    logic [7:0]  pr_saved     = SAVED_LEVEL_RST;
    phase_t      pr_phase     = PH_IDLE;
    logic [15:0] pr_count     = '0;
    logic [4:0]  pr_left      = '0;

    // Expected result words, oldest first.
    result_t     line_expect_q[$];

    int          n_fail         = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          quiet_cycles   = 0;

    // A programmed duration of zero still lasts one tick.
    function automatic logic [15:0] at_least_one(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    // Pulses owed for a raw two's complement level after clamping to 0..15.
    function automatic logic [4:0] pulse_total(input logic [7:0] raw);
        int lv;
        lv = int'($signed(raw));
        if (lv < 0)
            lv = 0;
        if (lv > int'(LEVEL_MAX))
            lv = int'(LEVEL_MAX);
        if (int'(cfg_step) <= lv)
            return 5'd0;
        return cfg_step - 5'(lv);
    endfunction

    function automatic void start_low_hold(input logic [4:0] pulses);
        pr_line  = 1'b0;
        pr_phase = PH_HOLD;
        pr_count = at_least_one(cfg_hold);
        pr_left  = pulses;
    endfunction

    // One time tick of the sequencer.
    function automatic void tick_advance();
        if (pr_phase == PH_IDLE)
            return;
        if (pr_count > 16'd1)
        begin
            pr_count = pr_count - 16'd1;
            return;
        end
        case (pr_phase)
            PH_HOLD:
            begin
                if (pr_left != 5'd0)
                begin
                    pr_phase = PH_KEEP;
                    pr_count = at_least_one({8'd0, cfg_pulse});
                end
                else
                begin
                    pr_phase = PH_IDLE;
                    pr_count = '0;
                end
            end
            PH_KEEP:
            begin
                pr_line  = 1'b0;
                pr_phase = PH_LOW;
                pr_count = at_least_one({8'd0, cfg_pulse});
            end
            default:
            begin
                // End of the low half: release the line, count the pulse.
                pr_line = 1'b1;
                pr_left = pr_left - 5'd1;
                if (pr_left != 5'd0)
                begin
                    pr_phase = PH_KEEP;
                    pr_count = at_least_one({8'd0, cfg_pulse});
                end
                else
                begin
                    pr_phase = PH_IDLE;
                    pr_count = '0;
                end
            end
        endcase
    endfunction

    // Apply one command word to the predictor and return the result it causes.
    function automatic result_t next_line_result(input cmd_t cmd, input logic [7:0] level);
        result_t r;
        logic    rej;
        rej = 1'b0;
        if (cmd == CMD_TICK)
            tick_advance();
        else if (pr_phase != PH_IDLE)
            rej = 1'b1;
        else
        begin
            case (cmd)
                CMD_SET_LEVEL:
                begin
                    // Level zero always turns the line off and is never stored.
                    if (level == 8'd0)
                        start_low_hold(5'd0);
                    else if (pr_suspended)
                        pr_saved = level;
                    else
                        start_low_hold(pulse_total(level));
                end
                CMD_SUSPEND:
                begin
                    start_low_hold(5'd0);
                    pr_suspended = 1'b1;
                end
                default:
                begin
                    start_low_hold(pulse_total(pr_saved));
                    pr_suspended = 1'b0;
                end
            endcase
        end
        r.line     = pr_line;
        r.busy_res = (pr_phase != PH_IDLE);
        r.rejected = rej;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] level;
        logic       settle;   // finish the running sequence first
        logic       typed;    // res holds the expected word
        result_t    res;      // {rejected, busy_res, line}
    } plan_row_t;

    plan_row_t directed_plan [PLAN_LEN] = '{
        // reset registers: hold 3000, half pulse 1, step 17, stored level 1
        '{CMD_TICK,      8'h00, 1'b0, 1'b1, 3'b000},  // tick while idle does nothing
        // hold 2, half pulse 1, step 3; stored level still at its reset value
        '{CMD_RESUME,    8'h00, 1'b0, 1'b1, 3'b010},  // replays the reset stored level
        '{CMD_SET_LEVEL, 8'h05, 1'b0, 1'b1, 3'b110},  // busy: rejected
        '{CMD_SUSPEND,   8'h00, 1'b0, 1'b1, 3'b110},  // busy: rejected
        '{CMD_SET_LEVEL, 8'h00, 1'b1, 1'b1, 3'b010},  // level zero: hold, no pulses
        '{CMD_SET_LEVEL, 8'h7F, 1'b1, 1'b0, 3'b000},  // clamps to 15, step not above it
        '{CMD_SET_LEVEL, 8'h80, 1'b1, 1'b0, 3'b000},  // most negative clamps to 0
        '{CMD_SET_LEVEL, 8'h02, 1'b1, 1'b0, 3'b000},
        '{CMD_SET_LEVEL, 8'h10, 1'b1, 1'b0, 3'b000},  // just above the clamp
        '{CMD_SET_LEVEL, 8'hFF, 1'b1, 1'b0, 3'b000},
        '{CMD_SET_LEVEL, 8'h01, 1'b0, 1'b1, 3'b110},  // busy: rejected
        '{CMD_TICK,      8'hA5, 1'b0, 1'b0, 3'b000},
        '{CMD_SUSPEND,   8'h00, 1'b1, 1'b1, 3'b010},
        '{CMD_SET_LEVEL, 8'h0C, 1'b1, 1'b1, 3'b000},  // suspended: only stored
        '{CMD_SET_LEVEL, 8'h00, 1'b0, 1'b1, 3'b010},  // suspended, level zero still holds
        '{CMD_SET_LEVEL, 8'h7F, 1'b1, 1'b0, 3'b000},  // suspended: stored raw
        '{CMD_RESUME,    8'h00, 1'b1, 1'b0, 3'b000},
        '{CMD_RESUME,    8'h00, 1'b1, 1'b0, 3'b000},  // resume while not suspended
        '{CMD_SET_LEVEL, 8'h55, 1'b1, 1'b0, 3'b000},  // not suspended: store untouched
        '{CMD_TICK,      8'h5A, 1'b1, 1'b0, 3'b000},
        '{CMD_SUSPEND,   8'h00, 1'b1, 1'b0, 3'b000},
        '{CMD_RESUME,    8'h00, 1'b0, 1'b1, 3'b110},  // busy: rejected
        '{CMD_TICK,      8'hFF, 1'b1, 1'b0, 3'b000}
    };

    // Register settings and idling per random phase; hold and half pulse of 0 act as 1.
    int ph_hold  [NUM_PHASES] = '{1, 5, 2, 0, 3, 65535};
    int ph_pulse [NUM_PHASES] = '{1, 3, 2, 0, 255, 7};
    int ph_step  [NUM_PHASES] = '{1, 17, 31, 9, 4, 31};
    int ph_send  [NUM_PHASES] = '{0, 84, 0, 31, 0, 31};
    int ph_recv  [NUM_PHASES] = '{0, 0, 84, 31, 0, 31};
    int ph_items [NUM_PHASES] = '{170, 210, 210, 210, 170, 170};

    // ------------------------------------------------------------------
    // Command driver
    // ------------------------------------------------------------------

    // Present one command word, hold it until taken, then idle at random.
    task automatic send_word(input cmd_t cmd, input logic [7:0] level,
                             input logic typed, input result_t want);
        result_t predicted;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= level;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = next_line_result(cmd, level);
        line_expect_q.push_back(typed ? want : predicted);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Feed ticks until the predicted sequence is over.
    task automatic settle_sequence();
        int n;
        n = 0;
        while (pr_phase != PH_IDLE && n < SETTLE_CAP)
        begin
            send_word(CMD_TICK, 8'($urandom_range(255)), 1'b0, '0);
            n++;
        end
    endtask

    // Drop valid, drain all expected words, then let the pipeline empty.
    task automatic go_quiet();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (line_expect_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all three registers, one handshake each.
    task automatic write_settings(input logic [15:0] hold, input logic [7:0] half,
                                  input logic [4:0] step);
        cfg_idx_t    idx_list [3];
        logic [15:0] val_list [3];
        idx_list = '{CFG_HOLD_TICKS, CFG_PULSE_TICKS, CFG_STEP_COUNT};
        val_list = '{hold, {8'd0, half}, {11'd0, step}};
        for (int k = 0; k < 3; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx_list[k];
            cfg_data  <= val_list[k];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (idx_list[k])
                CFG_HOLD_TICKS:  cfg_hold  = val_list[k];
                CFG_PULSE_TICKS: cfg_pulse = val_list[k][7:0];
                default:         cfg_step  = val_list[k][4:0];
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Random command: mostly ticks while a sequence runs, commands while idle.
    task automatic send_random_word();
        cmd_t       c;
        logic [7:0] lv;
        int         r;
        r = $urandom_range(99);
        if ((pr_phase != PH_IDLE) ? (r < 88) : (r < 40))
            c = CMD_TICK;
        else
        begin
            r = $urandom_range(9);
            if (r < 5)
                c = CMD_SET_LEVEL;
            else if (r < 7)
                c = CMD_SUSPEND;
            else
                c = CMD_RESUME;
        end
        r = $urandom_range(99);
        if (r < 20)
            lv = 8'd0;
        else if (r < 60)
            lv = 8'($urandom_range(17));
        else
            lv = 8'($urandom_range(255));
        send_word(c, lv, 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Result checker and sink backpressure
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[2:0]);
            if (line_expect_q.size() == 0)
            begin
                $error("result word %0h arrived with nothing expected", m_tdata);
                n_fail++;
            end
            else
            begin
                want = line_expect_q.pop_front();
                if (got.line !== want.line)
                begin
                    $error("line: expected %0b, got %0b", want.line, got.line);
                    n_fail++;
                end
                if (got.busy_res !== want.busy_res)
                begin
                    $error("busy_res: expected %0b, got %0b", want.busy_res, got.busy_res);
                    n_fail++;
                end
                if (got.rejected !== want.rejected)
                begin
                    $error("rejected: expected %0b, got %0b", want.rejected, got.rejected);
                    n_fail++;
                end
            end
        end
        // Stall the sink at random for the next cycle.
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: end the run if no channel moves a word for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table; after the reset row, switch to short durations
        // before any sequence starts so the sequences stay small.
        for (int i = 0; i < PLAN_LEN; i++)
        begin
            if (i == RESET_ROWS)
            begin
                settle_sequence();
                go_quiet();
                write_settings(16'd2, 8'd1, 5'd3);
            end
            if (directed_plan[i].settle)
                settle_sequence();
            send_word(directed_plan[i].cmd, directed_plan[i].level,
                      directed_plan[i].typed, directed_plan[i].res);
        end

        // Random phases; load the new settings first so a sequence left over from the
        // previous phase finishes on the new timing. The last phase leaves its very
        // long hold running at the end.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            go_quiet();
            write_settings(16'(ph_hold[p]), 8'(ph_pulse[p]), 5'(ph_step[p]));
            settle_sequence();
            send_idle_pct  = ph_send[p];
            recv_stall_pct = ph_recv[p];
            repeat (ph_items[p]) send_random_word();
        end

        go_quiet();
        repeat (4) @(posedge clk);
        if (n_fail == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: sim.f
rtl/pcbl_pkg.sv
rtl/pcbl_cfg_regs.sv
rtl/pcbl_in_stage.sv
rtl/pcbl_core.sv
rtl/pcbl_out_stage.sv
rtl/pulse_count_backlight_controller.sv
rtl/pcbl_checker.sv
tb/tb_pulse_count_backlight_controller.sv
